// File: rtl/core/tty_pkg.sv
// Shared constants, control types and echo sequence tables for the line discipline.
package tty_pkg;

    localparam int LINE_CAPACITY_DEF = 32;

    // Result destinations
    localparam logic [1:0] DEST_ECHO   = 2'd0;
    localparam logic [1:0] DEST_READER = 2'd1;
    localparam logic [1:0] DEST_SIGNAL = 2'd2;

    // Signal codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;

    // Special keys
    localparam logic [7:0] KEY_INTR  = 8'd3;
    localparam logic [7:0] KEY_EOF   = 8'd4;
    localparam logic [7:0] KEY_BS    = 8'd8;
    localparam logic [7:0] KEY_LF    = 8'd10;
    localparam logic [7:0] KEY_CLEAR = 8'd12;
    localparam logic [7:0] KEY_CR    = 8'd13;
    localparam logic [7:0] KEY_QUIT  = 8'd28;
    localparam logic [7:0] KEY_DEL   = 8'd127;

    // Key classes
    typedef logic [2:0] t_cls;
    localparam t_cls CLS_SIG   = 3'd0;
    localparam t_cls CLS_EOF   = 3'd1;
    localparam t_cls CLS_CLEAR = 3'd2;
    localparam t_cls CLS_ERASE = 3'd3;
    localparam t_cls CLS_NL    = 3'd4;
    localparam t_cls CLS_OTHER = 3'd5;

    // Fixed echo sequences
    typedef logic [2:0] t_seq;
    localparam t_seq SEQ_CLEAR = 3'd0;
    localparam t_seq SEQ_INTR  = 3'd1;
    localparam t_seq SEQ_QUIT  = 3'd2;
    localparam t_seq SEQ_ERASE = 3'd3;
    localparam t_seq SEQ_NL    = 3'd4;

    // Output register sources
    typedef logic [1:0] t_src;
    localparam t_src SRC_SIG  = 2'd0;
    localparam t_src SRC_SEQ  = 2'd1;
    localparam t_src SRC_BYTE = 2'd2;
    localparam t_src SRC_LINE = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       store;
        logic       len_inc;
        logic       len_dec;
        logic       len_clr;
        logic       idx_clr;
        logic       idx_inc;
        logic       sidx_clr;
        logic       sidx_inc;
        logic       load;
        t_src       src;
        t_seq       seq;
        logic [1:0] dest;
        logic       last;
    } t_cmd;

    typedef struct packed {
        t_cls       cls;
        logic       key_quit;
        logic       echo;
        logic       canon;
        logic       len_zero;
        logic       len_room;
        logic       idx_at_len;
        logic [2:0] sidx;
        logic       slot_free;
    } t_sts;

    function automatic logic [2:0] seq_last_idx(input t_seq seq);
        logic [2:0] r;
        r = 3'd2;
        case (seq)
            SEQ_CLEAR: r = 3'd6;
            SEQ_NL:    r = 3'd0;
            default:   r = 3'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] seq_byte(input t_seq seq, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'd0;
        case (seq)
            SEQ_CLEAR: begin
                case (idx)
                    3'd0, 3'd4: b = 8'd27;
                    3'd1, 3'd5: b = 8'd91;  // '['
                    3'd2:       b = 8'd50;  // '2'
                    3'd3:       b = 8'd74;  // 'J'
                    3'd6:       b = 8'd72;  // 'H'
                    default:    b = 8'd0;
                endcase
            end
            SEQ_INTR: begin
                case (idx)
                    3'd0:    b = 8'd94;     // '^'
                    3'd1:    b = 8'd67;     // 'C'
                    default: b = KEY_LF;
                endcase
            end
            SEQ_QUIT: begin
                case (idx)
                    3'd0:    b = 8'd94;     // '^'
                    3'd1:    b = 8'd92;     // backslash
                    default: b = KEY_LF;
                endcase
            end
            SEQ_ERASE: begin
                case (idx)
                    3'd1:    b = 8'd32;
                    default: b = KEY_BS;
                endcase
            end
            default: b = KEY_LF;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/tty_dp.sv
// Datapath: config registers, line store, counters and output register.
module tty_dp
    import tty_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_key_byte,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_out_stall,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    output logic [1:0] o_destination,
    output logic [7:0] o_byte_value,
    output logic [1:0] o_signal_code,
    output logic       o_last_of_run
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);

    logic             r_echo, r_canon;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [2:0]       r_sidx, n_sidx;
    logic [7:0]       r_byte;
    logic [1:0]       r_sig;
    logic [7:0]       r_mem [LINE_CAPACITY];
    logic [7:0]       r_rd;
    logic             r_ov;
    logic [1:0]       r_dest;
    logic [7:0]       r_val;
    logic [1:0]       r_code;
    logic             r_last;
    logic             slot_free;
    t_cls             cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo  <= 1'b1;
            r_canon <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index) r_canon <= i_cfg_data;
            else             r_echo  <= i_cfg_data;
        end
    end

    always_comb begin
        unique case (i_key_byte) inside
            KEY_INTR, KEY_QUIT: cls = CLS_SIG;
            KEY_EOF:            cls = CLS_EOF;
            KEY_CLEAR:          cls = CLS_CLEAR;
            KEY_BS, KEY_DEL:    cls = CLS_ERASE;
            KEY_LF, KEY_CR:     cls = CLS_NL;
            default:            cls = CLS_OTHER;
        endcase
    end

    always_comb begin
        n_len = r_len;
        if (i_cmd.len_clr)      n_len = '0;
        else if (i_cmd.len_inc) n_len = r_len + 1'b1;
        else if (i_cmd.len_dec) n_len = r_len - 1'b1;

        n_idx = r_idx;
        if (i_cmd.idx_clr)      n_idx = '0;
        else if (i_cmd.idx_inc) n_idx = r_idx + 1'b1;

        n_sidx = r_sidx;
        if (i_cmd.sidx_clr)      n_sidx = '0;
        else if (i_cmd.sidx_inc) n_sidx = r_sidx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_idx  <= '0;
            r_sidx <= '0;
        end else begin
            r_len  <= n_len;
            r_idx  <= n_idx;
            r_sidx <= n_sidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_key_byte;
            r_sig  <= (i_key_byte == KEY_QUIT) ? SIG_QUIT : SIG_INTR;
        end
    end

    // Line store; read data always tracks mem[r_idx]
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_mem[r_len] <= i_key_byte;
        r_rd <= r_mem[n_idx];
    end

    assign slot_free = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_cmd.last;
            case (i_cmd.src)
                SRC_SIG: begin
                    r_dest <= DEST_SIGNAL;
                    r_val  <= 8'd0;
                    r_code <= r_sig;
                end
                SRC_SEQ: begin
                    r_dest <= DEST_ECHO;
                    r_val  <= seq_byte(i_cmd.seq, r_sidx);
                    r_code <= SIG_NONE;
                end
                SRC_BYTE: begin
                    r_dest <= i_cmd.dest;
                    r_val  <= r_byte;
                    r_code <= SIG_NONE;
                end
                default: begin
                    r_dest <= DEST_READER;
                    r_val  <= (r_idx == r_len) ? KEY_LF : r_rd;
                    r_code <= SIG_NONE;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.cls        = cls;
        o_sts.key_quit   = (i_key_byte == KEY_QUIT);
        o_sts.echo       = r_echo;
        o_sts.canon      = r_canon;
        o_sts.len_zero   = (r_len == '0);
        o_sts.len_room   = (r_len != LEN_W'(LINE_CAPACITY - 1));
        o_sts.idx_at_len = (r_idx == r_len);
        o_sts.sidx       = r_sidx;
        o_sts.slot_free  = slot_free;
    end

    assign o_out_valid   = r_ov;
    assign o_destination = r_dest;
    assign o_byte_value  = r_val;
    assign o_signal_code = r_code;
    assign o_last_of_run = r_last;

endmodule

// File: rtl/core/tty_ctrl.sv
// Controller: decodes each key and sequences its results into the output register.
module tty_ctrl
    import tty_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SIG  = 3'd1;
    localparam logic [2:0] ST_SEQ  = 3'd2;
    localparam logic [2:0] ST_BYTE = 3'd3;
    localparam logic [2:0] ST_RAW  = 3'd4;
    localparam logic [2:0] ST_LINE = 3'd5;

    logic [2:0] r_state, n_state;
    t_seq       r_seq, n_seq;
    logic       r_follow, n_follow;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        o_cmd      = '0;
        o_cmd.seq  = r_seq;
        o_cmd.dest = DEST_ECHO;
        n_state    = r_state;
        n_seq      = r_seq;
        n_follow   = r_follow;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd.idx_clr  = 1'b1;
                o_cmd.sidx_clr = 1'b1;
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_follow     = 1'b0;
                    case (i_sts.cls)
                        CLS_SIG: begin
                            o_cmd.len_clr = 1'b1;
                            n_seq         = i_sts.key_quit ? SEQ_QUIT : SEQ_INTR;
                            n_state       = ST_SIG;
                        end
                        CLS_EOF: begin
                            if (i_sts.canon && !i_sts.len_zero) n_state = ST_LINE;
                        end
                        CLS_CLEAR: begin
                            n_seq   = SEQ_CLEAR;
                            n_state = ST_SEQ;
                        end
                        CLS_ERASE: begin
                            if (!i_sts.canon) begin
                                n_state = ST_RAW;
                            end else if (!i_sts.len_zero) begin
                                o_cmd.len_dec = 1'b1;
                                n_seq         = SEQ_ERASE;
                                if (i_sts.echo) n_state = ST_SEQ;
                            end
                        end
                        CLS_NL: begin
                            if (!i_sts.canon) begin
                                n_state = ST_RAW;
                            end else if (i_sts.echo) begin
                                n_seq    = SEQ_NL;
                                n_follow = 1'b1;
                                n_state  = ST_SEQ;
                            end else begin
                                n_state = ST_LINE;
                            end
                        end
                        default: begin
                            if (!i_sts.canon) begin
                                n_state = ST_RAW;
                            end else if (i_sts.len_room) begin
                                o_cmd.store   = 1'b1;
                                o_cmd.len_inc = 1'b1;
                                if (i_sts.echo) n_state = ST_BYTE;
                            end
                        end
                    endcase
                end
            end
            ST_SIG: begin
                if (i_sts.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_SIG;
                    o_cmd.last = !i_sts.echo;
                    n_state    = i_sts.echo ? ST_SEQ : ST_IDLE;
                end
            end
            ST_SEQ: begin
                if (i_sts.slot_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.src      = SRC_SEQ;
                    o_cmd.sidx_inc = 1'b1;
                    if (i_sts.sidx == seq_last_idx(r_seq)) begin
                        o_cmd.last = !r_follow;
                        n_state    = r_follow ? ST_LINE : ST_IDLE;
                    end
                end
            end
            ST_RAW: begin
                if (i_sts.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_BYTE;
                    o_cmd.dest = DEST_READER;
                    o_cmd.last = !i_sts.echo;
                    n_state    = i_sts.echo ? ST_BYTE : ST_IDLE;
                end
            end
            ST_BYTE: begin
                if (i_sts.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_BYTE;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_LINE: begin
                if (i_sts.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_LINE;
                    if (i_sts.idx_at_len) begin
                        o_cmd.last    = 1'b1;
                        o_cmd.len_clr = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seq    <= SEQ_NL;
            r_follow <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seq    <= n_seq;
            r_follow <= n_follow;
        end
    end

endmodule

// File: rtl/core/tty_line_discipline.sv
// Top level of the terminal line discipline: controller plus datapath.
//
// Takes one keyboard byte per input transfer and produces zero or more result
// transfers (echo bytes, reader bytes, signal notices), the final one flagged by
// o_last_of_run. Once a key is taken, its results leave through a single output
// register at one per cycle while the far side does not stall; the longest run,
// a newline on a full line with echo on, is the echoed newline, LINE_CAPACITY-1
// line bytes and the closing newline. A new key is taken as soon as the last
// result of the previous one is loaded into the output register, even if that
// result has not been transferred yet. The pending line lives in a
// LINE_CAPACITY-entry byte memory with a registered read port; the line holds
// at most LINE_CAPACITY-1 bytes, and further ordinary keys are dropped.
// Configuration (echo enable at index 0, canonical mode at index 1) is always
// ready and is to be written only while the block is idle. Both registers reset
// to 1.
module tty_line_discipline
    import tty_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // key input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_key_byte,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_destination,
    output logic [7:0] o_byte_value,
    output logic [1:0] o_signal_code,
    output logic       o_last_of_run,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Registers are plain flops, a write can land any cycle
    assign o_cfg_ready = 1'b1;

    tty_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tty_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_byte    (i_key_byte),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_destination (o_destination),
        .o_byte_value  (o_byte_value),
        .o_signal_code (o_signal_code),
        .o_last_of_run (o_last_of_run)
    );

    // Signal notices carry a code and no byte
    a_sig_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_destination == DEST_SIGNAL)
            |-> (o_byte_value == 8'd0 && o_signal_code != SIG_NONE))
        else $error("signal item malformed");

    // Stream items carry no signal code
    a_stream_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_destination != DEST_SIGNAL) |-> (o_signal_code == SIG_NONE))
        else $error("stream item with signal code");

    // Taking a key never coincides with loading a result
    a_accept_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !cmd.load)
        else $error("key taken while a result is loaded");

    // Clear screen always produces output, so the input closes behind it
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_key_byte == KEY_CLEAR) |=> o_in_stall)
        else $error("clear screen produced no run");

endmodule
